>>> design/sef_pkg.sv
// ============================================================================
// sef_pkg
// Shared constants and types for the STX/ETX escape frame encoder.
// ============================================================================
package sef_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] MarkStart = 8'h02;
  localparam logic [ByteW-1:0] MarkEnd   = 8'h03;
  localparam logic [ByteW-1:0] MarkEsc   = 8'h10;
  localparam logic [ByteW-1:0] EscFlip   = 8'h80;

  localparam int unsigned QueueDepth = 2;

  // Step positions in the per-word emit mask, sent lowest first.
  localparam int unsigned StepStart = 0;
  localparam int unsigned StepEsc   = 1;
  localparam int unsigned StepData  = 2;
  localparam int unsigned StepEnd   = 3;
  localparam int unsigned NumSteps  = 4;

  typedef logic [NumSteps-1:0] step_mask_t;

  typedef struct packed {
    logic             start;
    logic             esc;
    logic [ByteW-1:0] data;
    logic             fin;
  } entry_t;

endpackage

>>> design/sef_if.sv
// ============================================================================
// sef_in_if / sef_out_if
// Valid/ready channels carrying payload words in and line words out.
// ============================================================================
interface sef_in_if;
  import sef_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] payload_byte;
  logic             frame_end;

  modport source (output valid, output payload_byte, output frame_end, input ready);
  modport sink   (input valid, input payload_byte, input frame_end, output ready);
endinterface

interface sef_out_if;
  import sef_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] line_byte;
  logic             run_last;
  logic             frame_closed;

  modport source (output valid, output line_byte, output run_last, output frame_closed,
                  input ready);
  modport sink   (input valid, input line_byte, input run_last, input frame_closed,
                  output ready);
endinterface

>>> design/sef_front.sv
// ============================================================================
// sef_front
// Accept payload words, track the open frame and classify each word.
// ============================================================================
module sef_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  sef_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output sef_pkg::entry_t entry_o
);
  import sef_pkg::*;

  logic frame_open_q, frame_open_d;

  always_comb begin
    in_i.ready    = !full_i;
    push_o        = in_i.valid && !full_i;
    entry_o.start = !frame_open_q;
    entry_o.esc   = (in_i.payload_byte == MarkStart) || (in_i.payload_byte == MarkEnd) ||
                    (in_i.payload_byte == MarkEsc);
    entry_o.data  = entry_o.esc ? (in_i.payload_byte + EscFlip) : in_i.payload_byte;
    entry_o.fin   = in_i.frame_end;
    frame_open_d  = frame_open_q;
    if (push_o) begin
      frame_open_d = !in_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else begin
      frame_open_q <= frame_open_d;
    end
  end

endmodule

>>> design/sef_queue.sv
// ============================================================================
// sef_queue
// Short queue of classified words between front and back.
// ============================================================================
module sef_queue #(
  parameter int unsigned Depth = sef_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sef_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output sef_pkg::entry_t entry_o,
  output logic            empty_o
);
  import sef_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  always_comb begin
    full_o   = (cnt_q == CntFull);
    empty_o  = (cnt_q == '0);
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    entry_o  = mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> design/sef_back.sv
// ============================================================================
// sef_back
// Expand each queued word into markers and escapes, one line word a cycle while out_o is ready.
// ============================================================================
module sef_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sef_pkg::entry_t entry_i,
  input  logic            empty_i,
  output logic            pop_o,
  sef_out_if.source       out_o
);
  import sef_pkg::*;

  step_mask_t       pending_q, pending_d;
  logic [ByteW-1:0] data_q, data_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_closed_q, out_closed_d;

  logic             advance, use_entry;
  step_mask_t       eff_mask, sel, rest;
  logic [ByteW-1:0] eff_data;

  always_comb begin
    advance   = !out_valid_q || out_o.ready;
    use_entry = (pending_q == '0) && !empty_i;
    if (pending_q != '0) begin
      eff_mask = pending_q;
      eff_data = data_q;
    end else if (!empty_i) begin
      eff_mask = {entry_i.fin, 1'b1, entry_i.esc, entry_i.start};
      eff_data = entry_i.data;
    end else begin
      eff_mask = '0;
      eff_data = data_q;
    end
    sel  = eff_mask & (~eff_mask + 1'b1);
    rest = eff_mask & ~sel;

    pop_o        = advance && use_entry;
    pending_d    = pending_q;
    data_d       = data_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_closed_d = out_closed_q;

    if (advance) begin
      out_valid_d  = (eff_mask != '0);
      pending_d    = rest;
      data_d       = eff_data;
      out_last_d   = (rest == '0);
      out_closed_d = sel[StepEnd];
      unique case (1'b1)
        sel[StepStart]: out_byte_d = MarkStart;
        sel[StepEsc]:   out_byte_d = MarkEsc;
        sel[StepData]:  out_byte_d = eff_data;
        sel[StepEnd]:   out_byte_d = MarkEnd;
        default:        out_byte_d = out_byte_q;
      endcase
    end

    out_o.valid        = out_valid_q;
    out_o.line_byte    = out_byte_q;
    out_o.run_last     = out_last_q;
    out_o.frame_closed = out_closed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q       <= data_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
    out_closed_q <= out_closed_d;
  end

endmodule

>>> design/stx_etx_escape_frame_encoder.sv
// ============================================================================
// stx_etx_escape_frame_encoder
// STX/ETX framing encoder with escape stuffing of marker bytes.
// ============================================================================
// Usage:
//   in_i  carries one payload word (payload_byte, frame_end) per handshake.
//   out_o carries one line word (line_byte, run_last, frame_closed).
//   A word expands to 1 to 4 line words: start marker when a frame opens,
//   escape plus flipped byte for marker bytes, end marker on frame_end.
//   The first line word of an accepted word passes through the queue memory
//   and then the output register before it appears on out_o.
//   Throughput: one line word per cycle from the back end while out_o is
//   ready; a word holds the back end until all of its line words are sent,
//   so plain mid-frame words flow at one per cycle.
//   The front accepts while the queue (QueueDepth words) has room, so it
//   keeps taking words while a finished line word waits on out_o.
//   Reset clears the queue, the output register and the open-frame flag;
//   the next word then opens a new frame.
//   A receiver stall holds the output word and backs up the queue, then
//   drops in_i.ready once the queue is full.
// ============================================================================
module stx_etx_escape_frame_encoder #(
  parameter int unsigned QueueDepth = sef_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sef_in_if.sink    in_i,
  sef_out_if.source out_o
);
  import sef_pkg::*;

  entry_t front_entry, queue_entry;
  logic   push, pop, full, empty;

  sef_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (front_entry)
  );

  sef_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (queue_entry),
    .empty_o (empty)
  );

  sef_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (queue_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  a_closed_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.frame_closed |-> out_o.line_byte == MarkEnd && out_o.run_last)
    else $error("frame_closed on a word other than the final end marker");

  a_esc_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.line_byte == MarkEsc |-> !out_o.run_last)
    else $error("escape word marked as last of its run");

  a_esc_followed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.line_byte == MarkEsc |=>
      out_o.valid && (out_o.line_byte == (MarkStart + EscFlip) ||
                      out_o.line_byte == (MarkEnd + EscFlip) ||
                      out_o.line_byte == (MarkEsc + EscFlip)))
    else $error("escape word not followed by a flipped marker byte");

endmodule

>>> tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the STX/ETX escape frame encoder. Payload words are
// queued up front: a short directed set covering every marker byte, the byte
// extremes and single-word frames, then random frames of 1 to 8 words rich in
// marker bytes. A built-in predictor expands each accepted word into its line
// words. A monitor compares each line word against the oldest expected word,
// field by field. Both channels idle in random bursts, which stop near the
// end of the run.
// ============================================================================
module tb_top;
  import sef_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             frame_end;
  } payload_word_t;

  typedef struct packed {
    logic [ByteW-1:0] line_byte;
    logic             run_last;
    logic             frame_closed;
  } line_word_t;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned CalmTail    = 20;
  localparam int unsigned RandomWords = 90;
  localparam int unsigned DrainCycles = 8;

  logic clk_i;
  logic rst_ni;

  sef_in_if  in_if ();
  sef_out_if out_if ();

  payload_word_t payload_q[$];
  line_word_t    line_q[$];

  logic        frame_is_open = 1'b0;
  logic        calm          = 1'b0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_gap      = 0;

  stx_etx_escape_frame_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  function automatic void stuff_word(input payload_word_t w);
    logic [ByteW-1:0] seq [4];
    int               n;
    n = 0;
    if (!frame_is_open) begin
      seq[n] = MarkStart;
      n++;
      frame_is_open = 1'b1;
    end
    if (w.payload_byte inside {MarkStart, MarkEnd, MarkEsc}) begin
      seq[n]     = MarkEsc;
      seq[n + 1] = w.payload_byte + EscFlip;
      n += 2;
    end else begin
      seq[n] = w.payload_byte;
      n++;
    end
    if (w.frame_end) begin
      seq[n] = MarkEnd;
      n++;
      frame_is_open = 1'b0;
    end
    for (int k = 0; k < n; k++) begin
      line_q.push_back('{line_byte: seq[k], run_last: (k == n - 1),
                         frame_closed: (w.frame_end && k == n - 1)});
    end
  endfunction

  task automatic add_word(input logic [ByteW-1:0] b, input logic fin);
    payload_q.push_back('{payload_byte: b, frame_end: fin});
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Driver: hold the word until accepted, then predict and load the next.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic          next_valid;
    payload_word_t next_word;
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.payload_byte <= '0;
      in_if.frame_end    <= 1'b0;
    end else begin
      next_valid = in_if.valid;
      next_word  = '{payload_byte: in_if.payload_byte, frame_end: in_if.frame_end};
      if (in_if.valid && in_if.ready) begin
        stuff_word(next_word);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 16) - 1;
        end else if (payload_q.size() > 0) begin
          next_word  = payload_q.pop_front();
          next_valid = 1'b1;
        end
      end
      calm               <= (payload_q.size() < CalmTail);
      in_if.valid        <= next_valid;
      in_if.payload_byte <= next_word.payload_byte;
      in_if.frame_end    <= next_word.frame_end;
    end
  end

  // Monitor: check each line word against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    line_word_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (line_q.size() == 0) begin
          $error("line word %h with no expectation pending", out_if.line_byte);
          fail_count++;
        end else begin
          want = line_q.pop_front();
          if (out_if.line_byte !== want.line_byte) begin
            $error("line_byte: expected %h, actual %h", want.line_byte, out_if.line_byte);
            fail_count++;
          end
          if (out_if.run_last !== want.run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, out_if.run_last);
            fail_count++;
          end
          if (out_if.frame_closed !== want.frame_closed) begin
            $error("frame_closed: expected %b, actual %b", want.frame_closed,
                   out_if.frame_closed);
            fail_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 16) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned      n_random;
    int unsigned      len;
    logic [ByteW-1:0] b;
    rst_ni = 1'b0;

    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(MarkStart, 1'b0);
    add_word(MarkEnd, 1'b0);
    add_word(MarkEsc, 1'b1);
    add_word(MarkStart, 1'b1);
    add_word(MarkEnd, 1'b1);
    add_word(MarkEsc, 1'b1);
    add_word(8'h41, 1'b1);
    add_word(8'h01, 1'b0);
    add_word(8'h04, 1'b0);
    add_word(8'h0F, 1'b0);
    add_word(8'h11, 1'b0);
    add_word(MarkStart + EscFlip, 1'b0);
    add_word(MarkEnd + EscFlip, 1'b0);
    add_word(MarkEsc + EscFlip, 1'b0);
    add_word(EscFlip, 1'b1);
    add_word(MarkEsc, 1'b0);
    add_word(MarkEsc, 1'b0);
    add_word(8'hFF, 1'b1);

    n_random = 0;
    while (n_random < RandomWords) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 2))
            0:       b = MarkStart;
            1:       b = MarkEnd;
            default: b = MarkEsc;
          endcase
        end else begin
          b = ByteW'($urandom_range(0, 255));
        end
        add_word(b, (i == len - 1));
        n_random++;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (payload_q.size() > 0 || in_if.valid || line_q.size() > 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_count == 0 && line_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
